[rtl/i2cms_pkg.sv]
package i2cms_pkg;

    // Bus command codes as they arrive on the op field.
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_WAIT_ACK = 3'd4,
        OP_SEND_ACK = 3'd5
    } t_op;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        t_op        op;
        logic [7:0] tx_byte;
        logic [7:0] sda_samples;
    } t_cmd;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 2;

endpackage

[rtl/i2c_master_bit_sequencer.sv]
// After a command's first pin step, later steps follow one per cycle while
// results are popped. Throughput: one pin step per cycle, set by the step
// sequencer; a write byte is 25 steps, read byte 16, start 4, send ack 4,
// stop and wait ack 3.
// Reset (synchronous, active low) empties both queues and releases SCL and SDA.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic [7:0] i_sda_samples,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl,
    output logic       o_sda,
    output logic [7:0] o_rx_byte,
    output logic       o_nack,
    output logic       o_last
);

    // The front end accepts command beats, drops unknown codes and parks
    // the rest in a short command queue. The back end turns the command at
    // the head of that queue into single pin steps, one per result beat,
    // and holds each step in an output register until it is popped. With
    // the queue in between, new commands keep coming in while a long write
    // is still being played out on the pins.
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    i2cms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_tx_byte     (i_tx_byte),
        .i_sda_samples (i_sda_samples),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    // The back end keeps the current SCL and SDA levels, so each result
    // beat shows both pins after the write it stands for. The next command
    // is loaded in the same cycle that the last step of the current one
    // goes out, so back-to-back commands leave no gap on the result side.
    i2cms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_scl       (o_scl),
        .o_sda       (o_sda),
        .o_rx_byte   (o_rx_byte),
        .o_nack      (o_nack),
        .o_last      (o_last)
    );

endmodule

[rtl/i2cms_front.sv]
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic [7:0] i_sda_samples,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_take
);

    localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CW = $clog2(CMD_DEPTH + 1);

    t_cmd          r_slot [CMD_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    logic op_known;
    logic enq;
    logic deq;

    // Codes beyond send-ack are taken and dropped: they make no pin steps.
    assign op_known    = (i_op <= 3'(OP_SEND_ACK));
    assign o_full      = (r_count == CW'(CMD_DEPTH));
    assign enq         = i_push && !o_full && op_known;
    assign o_cmd_valid = (r_count != '0);
    assign deq         = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == AW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == AW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (enq && !deq) begin
            n_count = r_count + 1'b1;
        end else if (deq && !enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slot[r_wr_ptr] <= '{op: t_op'(i_op), tx_byte: i_tx_byte,
                                  sda_samples: i_sda_samples};
        end
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CMD_DEPTH))
        else $error("command queue count beyond depth");

    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !deq) |=> o_full)
        else $error("command queue lost an entry while full");
`endif

endmodule

[rtl/i2cms_back.sv]
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_take,
    output logic       o_empty,
    input  logic       i_pop,
    output logic       o_scl,
    output logic       o_sda,
    output logic [7:0] o_rx_byte,
    output logic       o_nack,
    output logic       o_last
);

    localparam logic [4:0] START_LAST = 5'd3;
    localparam logic [4:0] STOP_LAST  = 5'd2;
    localparam logic [4:0] WRITE_LAST = 5'd24;
    localparam logic [4:0] READ_LAST  = 5'd15;
    localparam logic [4:0] WAIT_LAST  = 5'd2;
    localparam logic [4:0] SEND_LAST  = 5'd3;

    // Command in progress.
    logic       r_busy;
    t_op        r_op;
    logic [7:0] r_shift;
    logic [7:0] r_samp;
    logic [4:0] r_step;
    logic [1:0] r_phase;

    // Pin levels kept across commands.
    logic       r_scl;
    logic       r_sda;

    // Output stage.
    logic       r_out_valid;
    logic       r_o_scl;
    logic       r_o_sda;
    logic [7:0] r_o_rx;
    logic       r_o_nack;
    logic       r_o_last;

    logic       step_is_scl;
    logic       step_level;
    logic       step_last;
    logic       advance;
    logic       take;

    always_comb begin
        step_is_scl = 1'b0;
        step_level  = 1'b1;
        step_last   = 1'b1;
        case (r_op)
            OP_START: begin
                step_is_scl = r_step[0];
                step_level  = !r_step[1];
                step_last   = (r_step == START_LAST);
            end
            OP_STOP: begin
                step_is_scl = (r_step == 5'd1);
                step_level  = (r_step != 5'd0);
                step_last   = (r_step == STOP_LAST);
            end
            OP_WRITE: begin
                step_last = (r_step == WRITE_LAST);
                if (step_last) begin
                    step_is_scl = 1'b0;
                    step_level  = 1'b1;
                end else if (r_phase == 2'd0) begin
                    step_is_scl = 1'b0;
                    step_level  = r_shift[7];
                end else begin
                    step_is_scl = 1'b1;
                    step_level  = (r_phase == 2'd1);
                end
            end
            OP_READ: begin
                step_is_scl = 1'b1;
                step_level  = !r_step[0];
                step_last   = (r_step == READ_LAST);
            end
            OP_WAIT_ACK: begin
                step_is_scl = (r_step != 5'd0);
                step_level  = (r_step != 5'd2);
                step_last   = (r_step == WAIT_LAST);
            end
            OP_SEND_ACK: begin
                step_is_scl = (r_step == 5'd1) || (r_step == 5'd2);
                step_level  = r_step[0];
                step_last   = (r_step == SEND_LAST);
            end
            default: begin
                step_is_scl = 1'b0;
                step_level  = 1'b1;
                step_last   = 1'b1;
            end
        endcase
    end

    // A step goes out whenever a command is in progress and the output stage is free or being drained.
    assign advance    = r_busy && (!r_out_valid || i_pop);
    assign take       = i_cmd_valid && (!r_busy || (advance && step_last));
    assign o_cmd_take = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (advance && step_last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                if (step_is_scl) begin
                    r_scl <= step_level;
                end else begin
                    r_sda <= step_level;
                end
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op    <= i_cmd.op;
            r_shift <= i_cmd.tx_byte;
            r_samp  <= i_cmd.sda_samples;
            r_step  <= '0;
            r_phase <= '0;
        end else if (advance) begin
            r_step <= r_step + 1'b1;
            if (r_phase == 2'd2) begin
                r_phase <= '0;
                r_shift <= {r_shift[6:0], 1'b0};
            end else begin
                r_phase <= r_phase + 1'b1;
            end
        end
        if (advance) begin
            r_o_scl  <= step_is_scl ? step_level : r_scl;
            r_o_sda  <= step_is_scl ? r_sda : step_level;
            r_o_rx   <= (r_op == OP_READ && step_last) ? r_samp : 8'd0;
            r_o_nack <= (r_op == OP_WAIT_ACK && step_last) ? r_samp[7] : 1'b0;
            r_o_last <= step_last;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_scl     = r_o_scl;
    assign o_sda     = r_o_sda;
    assign o_rx_byte = r_o_rx;
    assign o_nack    = r_o_nack;
    assign o_last    = r_o_last;

`ifndef SYNTHESIS
    a_nack_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_nack) |-> r_o_last)
        else $error("nack reported on a step that is not the last");

    a_rx_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_rx != 8'd0) |-> r_o_last)
        else $error("read byte reported on a step that is not the last");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= WRITE_LAST))
        else $error("step counter ran past the longest command");
`endif

endmodule

[tb/tb_i2c_master_bit_sequencer.sv]
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer;
    import i2cms_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 240;
    // Once no more than this many commands are left to send, both sides stop idling.
    localparam int TAIL_ITEMS     = 30;
    // Length of the long receiver hold-off that lets the block fill up.
    localparam int LONG_HOLD      = 400;
    localparam int FIRST_HOLD_AT  = 150;
    localparam int HOLD_SPACING   = 1200;
    // Quiet cycles after the last expected pin step, to catch stray output beats.
    localparam int DRAIN_CYCLES   = 40;
    // The longest correct stretch without any accepted beat is a long hold-off
    // plus latency and idling, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;

    // The two op codes that the block has no command for and must ignore.
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic [7:0] sda_samples;
    } t_bus_cmd;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rx_byte;
        logic       nack;
        logic       last;
    } t_pin_step;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic       full;
    logic [2:0] i_op          = 3'd0;
    logic [7:0] i_tx_byte     = 8'd0;
    logic [7:0] i_sda_samples = 8'd0;
    logic       empty;
    logic       pop           = 1'b0;
    logic       o_scl;
    logic       o_sda;
    logic [7:0] o_rx_byte;
    logic       o_nack;
    logic       o_last;

    i2c_master_bit_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_tx_byte     (i_tx_byte),
        .i_sda_samples (i_sda_samples),
        .empty         (empty),
        .pop           (pop),
        .o_scl         (o_scl),
        .o_sda         (o_sda),
        .o_rx_byte     (o_rx_byte),
        .o_nack        (o_nack),
        .o_last        (o_last)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pin-level predictor. It keeps its own copy of the SCL and SDA levels,
    // which survive from one command to the next, and turns each accepted
    // command into the ordered list of pin writes the block must produce.
    // ------------------------------------------------------------------
    logic      bus_scl;
    logic      bus_sda;
    t_pin_step pin_steps_due[$];
    int        cmds_ignored = 0;

    // Every pin write is one output beat, even if the level does not change.
    task automatic note_pin_write(input logic [7:0] rx, input logic nk, input logic lst);
        t_pin_step s;
        s.scl     = bus_scl;
        s.sda     = bus_sda;
        s.rx_byte = rx;
        s.nack    = nk;
        s.last    = lst;
        pin_steps_due.push_back(s);
    endtask

    task automatic write_sda(input logic v, input logic lst);
        bus_sda = v;
        note_pin_write(8'd0, 1'b0, lst);
    endtask

    task automatic write_scl(input logic v, input logic [7:0] rx, input logic nk,
                             input logic lst);
        bus_scl = v;
        note_pin_write(rx, nk, lst);
    endtask

    task automatic predict_pin_steps(input t_bus_cmd cmd);
        case (cmd.op)
            OP_START: begin
                // SDA falls while SCL is high, then SCL is pulled low.
                write_sda(1'b1, 1'b0);
                write_scl(1'b1, 8'd0, 1'b0, 1'b0);
                write_sda(1'b0, 1'b0);
                write_scl(1'b0, 8'd0, 1'b0, 1'b1);
            end
            OP_STOP: begin
                // SDA rises while SCL is high.
                write_sda(1'b0, 1'b0);
                write_scl(1'b1, 8'd0, 1'b0, 1'b0);
                write_sda(1'b1, 1'b1);
            end
            OP_WRITE: begin
                // MSB first; SDA is released after the clock of the last bit.
                for (int i = 7; i >= 0; i--) begin
                    write_sda(cmd.tx_byte[i], 1'b0);
                    write_scl(1'b1, 8'd0, 1'b0, 1'b0);
                    write_scl(1'b0, 8'd0, 1'b0, 1'b0);
                end
                write_sda(1'b1, 1'b1);
            end
            OP_READ: begin
                // SCL is pulsed for each bit of the byte; the assembled byte rides on the final step only.
                for (int i = 0; i < 8; i++) begin
                    write_scl(1'b1, 8'd0, 1'b0, 1'b0);
                    write_scl(1'b0, (i == 7) ? cmd.sda_samples : 8'd0, 1'b0, i == 7);
                end
            end
            OP_WAIT_ACK: begin
                // Only the first sample counts; a high level there is a nack.
                write_sda(1'b1, 1'b0);
                write_scl(1'b1, 8'd0, 1'b0, 1'b0);
                write_scl(1'b0, 8'd0, cmd.sda_samples[7], 1'b1);
            end
            OP_SEND_ACK: begin
                write_sda(1'b0, 1'b0);
                write_scl(1'b1, 8'd0, 1'b0, 1'b0);
                write_scl(1'b0, 8'd0, 1'b0, 1'b0);
                write_sda(1'b1, 1'b1);
            end
            default: begin
                // A reserved code produces nothing and leaves the pins alone.
                cmds_ignored++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command driver. It offers the head of the command list, holds the beat
    // steady while the block reports full, and now and then leaves a random
    // gap. The gaps come and go in stretches, and stop for the tail.
    // ------------------------------------------------------------------
    t_bus_cmd cmds_to_send[$];
    int       cmds_accepted = 0;
    int       gap_left      = 0;
    bit       tx_quiet      = 1'b0;
    bit       tail_phase    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_pin_steps(cmds_to_send[0]);
                void'(cmds_to_send.pop_front());
                cmds_accepted++;
            end
            tail_phase <= (cmds_to_send.size() <= TAIL_ITEMS);
            if ($urandom_range(0, 63) == 0) begin
                tx_quiet <= ~tx_quiet;
            end
            if (push && full) begin
                // The beat was refused; keep offering it unchanged.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push     <= 1'b0;
            end else if (cmds_to_send.size() == 0) begin
                push <= 1'b0;
            end else if (!tail_phase && !tx_quiet && $urandom_range(0, 4) == 0) begin
                gap_left <= $urandom_range(0, 7);
                push     <= 1'b0;
            end else begin
                push          <= 1'b1;
                i_op          <= cmds_to_send[0].op;
                i_tx_byte     <= cmds_to_send[0].tx_byte;
                i_sda_samples <= cmds_to_send[0].sda_samples;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pin-step monitor. Every accepted output beat is checked field by field
    // against the oldest predicted step. The pop side idles in short random
    // bursts, and every so often it holds off for a long stretch so that the
    // block's queues fill up and push meets full.
    // ------------------------------------------------------------------
    int        errors         = 0;
    int        steps_checked  = 0;
    int        hold_left      = 0;
    int        next_long_hold = FIRST_HOLD_AT;
    int        long_holds     = 0;
    bit        rx_quiet       = 1'b0;
    t_pin_step want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                steps_checked++;
                if (pin_steps_due.size() == 0) begin
                    $error("pin step with no command behind it: scl=%0d sda=%0d last=%0d",
                           o_scl, o_sda, o_last);
                    errors++;
                end else begin
                    want = pin_steps_due.pop_front();
                    if (o_scl !== want.scl) begin
                        $error("scl: expected %0d, got %0d", want.scl, o_scl);
                        errors++;
                    end
                    if (o_sda !== want.sda) begin
                        $error("sda: expected %0d, got %0d", want.sda, o_sda);
                        errors++;
                    end
                    if (o_rx_byte !== want.rx_byte) begin
                        $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx_byte, o_rx_byte);
                        errors++;
                    end
                    if (o_nack !== want.nack) begin
                        $error("nack: expected %0d, got %0d", want.nack, o_nack);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) begin
                rx_quiet <= ~rx_quiet;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else if (!tail_phase && steps_checked >= next_long_hold) begin
                hold_left      <= LONG_HOLD - 1;
                next_long_hold <= next_long_hold + HOLD_SPACING;
                long_holds     <= long_holds + 1;
                pop            <= 1'b0;
            end else if (!tail_phase && !rx_quiet && $urandom_range(0, 4) == 0) begin
                hold_left <= $urandom_range(0, 7);
                pop       <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops moving beats in either direction is hung.
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic queue_cmd(input logic [2:0] op, input logic [7:0] tx, input logic [7:0] samp);
        t_bus_cmd c;
        c.op          = op;
        c.tx_byte     = tx;
        c.sda_samples = samp;
        cmds_to_send.push_back(c);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial begin
        int random_target;
        int body_len;

        bus_scl = 1'b1;
        bus_sda = 1'b1;

        // Directed part: field extremes, every command, repeated start and
        // stop, the ignored codes, and the sample bits that must not matter.
        queue_cmd(OP_START,    8'h00, 8'h00);
        queue_cmd(OP_START,    8'hFF, 8'hFF);
        queue_cmd(OP_WRITE,    8'h00, 8'h00);
        queue_cmd(OP_WRITE,    8'hFF, 8'hFF);
        queue_cmd(OP_WRITE,    8'hA5, 8'h00);
        queue_cmd(OP_WRITE,    8'h5A, 8'hFF);
        queue_cmd(OP_WAIT_ACK, 8'h00, 8'h00);
        queue_cmd(OP_WAIT_ACK, 8'hFF, 8'h80);
        queue_cmd(OP_WAIT_ACK, 8'h00, 8'h7F);
        queue_cmd(OP_WAIT_ACK, 8'hFF, 8'hFF);
        queue_cmd(OP_READ,     8'h00, 8'h00);
        queue_cmd(OP_READ,     8'hFF, 8'hFF);
        queue_cmd(OP_READ,     8'h00, 8'h5A);
        queue_cmd(OP_SEND_ACK, 8'hFF, 8'hFF);
        queue_cmd(OP_SEND_ACK, 8'h00, 8'h00);
        queue_cmd(OP_RSVD_6,   8'hFF, 8'hFF);
        queue_cmd(OP_RSVD_7,   8'h00, 8'h00);
        queue_cmd(OP_STOP,     8'h00, 8'h00);
        queue_cmd(OP_STOP,     8'hFF, 8'hFF);
        queue_cmd(OP_RSVD_7,   8'hFF, 8'h80);
        queue_cmd(OP_READ,     8'h00, 8'h80);
        queue_cmd(OP_WRITE,    8'h01, 8'h00);
        queue_cmd(OP_STOP,     8'h00, 8'h00);

        // Random part: mostly whole bus transfers with random content,
        // salted with stray commands and transfers that never see a stop.
        random_target = cmds_to_send.size() + RANDOM_ITEMS;
        while (cmds_to_send.size() < random_target) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_cmd(3'($urandom_range(0, 7)), rand_byte(), rand_byte());
            end else begin
                queue_cmd(OP_START, rand_byte(), rand_byte());
                queue_cmd(OP_WRITE, rand_byte(), rand_byte());
                queue_cmd(OP_WAIT_ACK, rand_byte(), rand_byte());
                body_len = $urandom_range(1, 4);
                for (int k = 0; k < body_len; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        queue_cmd(OP_WRITE, rand_byte(), rand_byte());
                        queue_cmd(OP_WAIT_ACK, rand_byte(), rand_byte());
                    end else begin
                        queue_cmd(OP_READ, rand_byte(), rand_byte());
                        // The final read of a transfer usually goes unacknowledged.
                        if (k != body_len - 1 || $urandom_range(0, 3) == 0) begin
                            queue_cmd(OP_SEND_ACK, rand_byte(), rand_byte());
                        end
                    end
                end
                // A missing stop usually leads straight into a repeated start.
                if ($urandom_range(0, 3) != 0) begin
                    queue_cmd(OP_STOP, rand_byte(), rand_byte());
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_to_send.size() != 0 || push) @(posedge i_clk);
        while (pin_steps_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bus commands, %0d of them reserved codes, and checked %0d pin steps.",
                 cmds_accepted, cmds_ignored, steps_checked);
        $display("The receiver held off for %0d cycles on %0d occasions to back up the block.",
                 LONG_HOLD, long_holds);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
